// ----- rtl/vtg_pkg.sv -----
// ----------------------------------------------------------------------------
// vtg_pkg
// Shared types and constants for the vertex texture coordinate generator.
// ----------------------------------------------------------------------------
package vtg_pkg;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_MODE     = 3'd0;
	localparam logic [2:0] REG_FACTOR_U = 3'd1;
	localparam logic [2:0] REG_FACTOR_V = 3'd2;
	localparam logic [2:0] REG_OFFSET_U = 3'd3;
	localparam logic [2:0] REG_OFFSET_V = 3'd4;

	// Mapping modes (the unused code behaves as planar)
	localparam logic [1:0] MODE_PLANAR    = 2'd0;
	localparam logic [1:0] MODE_SPHERICAL = 2'd1;
	localparam logic [1:0] MODE_BOX       = 2'd2;

	// Datapath widths
	localparam int XW = 36;   // CORDIC x / y
	localparam int ZW = 34;   // CORDIC angle, Q2.30
	localparam int CW = 33;   // coordinate entering the scale stage
	localparam int SQ_STEPS = 32;   // one result bit per square root cell

	// pi in Q2.30
	localparam logic [32:0] PI_Q30 = 33'd3373259426;

	// atan(2^-i) in Q2.30
	localparam logic [29:0] ATAN_Q30 [32] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
		30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
		30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
		30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
	};

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] tex_u;
		logic signed [31:0] tex_v;
	} out_item_t;

	// Rotation state of one CORDIC cell
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	// Remainder and partial root of one square root cell
	typedef struct packed {
		logic [63:0] n;
		logic [63:0] res;
	} isqrt_t;

	// Per-vertex data that rides along the cell chains
	typedef struct packed {
		logic                 sph;
		logic                 yneg;
		logic [31:0]          ax;
		logic [31:0]          az;
		logic [31:0]          ay;
		logic signed [CW-1:0] cu;
		logic signed [CW-1:0] cv;
	} side_t;

endpackage

// ----- rtl/vtg_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// vtg_cordic_cell
// One vectoring micro-rotation by 2^-IDX, with the vertex data carried along.
// ----------------------------------------------------------------------------
module vtg_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  vtg_pkg::cordic_t in_st,
	input  vtg_pkg::side_t   in_side,
	output logic             out_valid,
	output vtg_pkg::cordic_t out_st,
	output vtg_pkg::side_t   out_side
);

	localparam logic signed [vtg_pkg::ZW-1:0] ATAN =
		vtg_pkg::ZW'(vtg_pkg::ATAN_Q30[IDX]);

	logic             valid_q;
	vtg_pkg::cordic_t st_q;
	vtg_pkg::side_t   side_q;
	vtg_pkg::cordic_t nxt;
	logic signed [vtg_pkg::XW-1:0] dx, dy;

	// Rotate toward the x axis (floor shifts)
	always_comb begin
		dx = in_st.y >>> IDX;
		dy = in_st.x >>> IDX;
		if (!in_st.y[vtg_pkg::XW-1]) begin
			nxt.x = in_st.x + dx;
			nxt.y = in_st.y - dy;
			nxt.z = in_st.z + ATAN;
		end else begin
			nxt.x = in_st.x - dx;
			nxt.y = in_st.y + dy;
			nxt.z = in_st.z - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q   <= nxt;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_st    = st_q;
	assign out_side  = side_q;

endmodule

// ----- rtl/vtg_isqrt_cell.sv -----
// ----------------------------------------------------------------------------
// vtg_isqrt_cell
// One digit step of the integer square root, trial bit 4^(31-K).
// ----------------------------------------------------------------------------
module vtg_isqrt_cell #(
	parameter int K = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  vtg_pkg::isqrt_t in_st,
	input  vtg_pkg::side_t  in_side,
	output logic            out_valid,
	output vtg_pkg::isqrt_t out_st,
	output vtg_pkg::side_t  out_side
);

	localparam logic [63:0] BIT = 64'd1 << (62 - 2 * K);

	logic            valid_q;
	vtg_pkg::isqrt_t st_q;
	vtg_pkg::side_t  side_q;
	vtg_pkg::isqrt_t nxt;
	logic [63:0]     trial;

	// Subtract the trial value when it fits
	always_comb begin
		trial = in_st.res + BIT;
		if (in_st.n >= trial) begin
			nxt.n   = in_st.n - trial;
			nxt.res = (in_st.res >> 1) + BIT;
		end else begin
			nxt.n   = in_st.n;
			nxt.res = in_st.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q   <= nxt;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_st    = st_q;
	assign out_side  = side_q;

endmodule

// ----- rtl/vtg_affine.sv -----
// ----------------------------------------------------------------------------
// vtg_affine
// Scale, offset and saturate both coordinates; two stages, output registered.
// ----------------------------------------------------------------------------
module vtg_affine #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [vtg_pkg::CW-1:0] cu,
	input  logic signed [vtg_pkg::CW-1:0] cv,
	input  logic signed [31:0]            factor_u,
	input  logic signed [31:0]            factor_v,
	input  logic signed [31:0]            offset_u,
	input  logic signed [31:0]            offset_v,
	output logic                          out_valid,
	output vtg_pkg::out_item_t            out_data
);

	localparam int PW = vtg_pkg::CW + 32;

	logic                 valid_s1, valid_s2;
	logic signed [PW-1:0] prod_u_s1, prod_v_s1;
	vtg_pkg::out_item_t   data_s2;

	function automatic logic signed [31:0] scale_sat(logic signed [PW-1:0] p,
		logic signed [31:0] o);
		logic signed [PW-1:0] sh;
		logic signed [PW:0]   s;
		sh = p >>> FRAC_BITS;
		s  = (PW + 1)'(sh) + (PW + 1)'(o);
		if (s > (PW + 1)'(32'sh7fffffff)) begin
			return 32'sh7fffffff;
		end else if (s < -(PW + 1)'(33'sh080000000)) begin
			return 32'sh80000000;
		end else begin
			return s[31:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Products, then floor shift, offset and clamp
	always_ff @(posedge clk) begin
		if (en) begin
			prod_u_s1     <= PW'(cu) * PW'(factor_u);
			prod_v_s1     <= PW'(cv) * PW'(factor_v);
			data_s2.tex_u <= scale_sat(prod_u_s1, offset_u);
			data_s2.tex_v <= scale_sat(prod_v_s1, offset_v);
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ----- rtl/vertex_texcoord_generator_core.sv -----
// ----------------------------------------------------------------------------
// vertex_texcoord_generator_core
// Per-vertex texture coordinate generation: planar, spherical or box mapping.
// ----------------------------------------------------------------------------
// Takes one vertex per clock while the output is not stalled and returns one
// (tex_u, tex_v) per vertex, in order, through one input register, a chain
// of CORDIC_STEPS rotation cells for u, registers that square and then sum
// to form x^2 + z^2, a chain of 32 square root cells, a second chain of
// CORDIC_STEPS cells for v, one rounding register and two scale stages. All
// modes use the same path. The chain advances as a whole whenever the output
// register is empty or being taken, so in_ready only drops while a result
// waits on a stalled output. Configuration is sampled live and must be
// written while no vertex is in flight.
module vertex_texcoord_generator_core #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  vtg_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output vtg_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata
);

	localparam int          SH     = 30 - FRAC_BITS;
	localparam logic [31:0] STEP_Q = 32'(((1 << FRAC_BITS) + 5) / 10);
	localparam logic [vtg_pkg::ZW:0] HALF = (vtg_pkg::ZW + 1)'(1) << (SH - 1);

	// Configuration registers
	logic [1:0]         mode_q;
	logic signed [31:0] factor_u_q, factor_v_q, offset_u_q, offset_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= vtg_pkg::MODE_PLANAR;
			factor_u_q <= 32'sd65536;
			factor_v_q <= 32'sd65536;
			offset_u_q <= 32'sd0;
			offset_v_q <= 32'sd0;
		end else if (cfg_we) begin
			case (cfg_idx)
				vtg_pkg::REG_MODE:     mode_q     <= cfg_wdata[1:0];
				vtg_pkg::REG_FACTOR_U: factor_u_q <= cfg_wdata;
				vtg_pkg::REG_FACTOR_V: factor_v_q <= cfg_wdata;
				vtg_pkg::REG_OFFSET_U: offset_u_q <= cfg_wdata;
				vtg_pkg::REG_OFFSET_V: offset_v_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Global advance: hold everything while a result waits
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Front end: absolute values, mode selection, spherical clamp
	logic [31:0]    ax, ay, az;
	logic [15:0]    nx, ny, nz;
	vtg_pkg::side_t side_in;

	always_comb begin
		ax = in_data.pos_x[31] ? 32'(-in_data.pos_x) : 32'(in_data.pos_x);
		ay = in_data.pos_y[31] ? 32'(-in_data.pos_y) : 32'(in_data.pos_y);
		az = in_data.pos_z[31] ? 32'(-in_data.pos_z) : 32'(in_data.pos_z);
		nx = in_data.normal_x[15] ? 16'(-in_data.normal_x) : 16'(in_data.normal_x);
		ny = in_data.normal_y[15] ? 16'(-in_data.normal_y) : 16'(in_data.normal_y);
		nz = in_data.normal_z[15] ? 16'(-in_data.normal_z) : 16'(in_data.normal_z);
		side_in.sph  = (mode_q == vtg_pkg::MODE_SPHERICAL);
		side_in.yneg = in_data.pos_y[31];
		side_in.ay   = ay;
		if (ax < STEP_Q && az < STEP_Q) begin
			side_in.ax = STEP_Q;
			side_in.az = STEP_Q;
		end else begin
			side_in.ax = ax;
			side_in.az = az;
		end
		case (mode_q)
			vtg_pkg::MODE_BOX: begin
				if (nz > nx && nz > ny) begin
					side_in.cu = {1'b0, ax};
					side_in.cv = {1'b0, ay};
				end else if (ny > nx) begin
					side_in.cu = {1'b0, ax};
					side_in.cv = -$signed({1'b0, az});
				end else begin
					side_in.cu = -$signed({1'b0, az});
					side_in.cv = {1'b0, ay};
				end
			end
			default: begin
				side_in.cu = vtg_pkg::CW'(in_data.pos_x);
				side_in.cv = vtg_pkg::CW'(in_data.pos_y);
			end
		endcase
	end

	logic           valid_s0;
	vtg_pkg::side_t side_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (en) begin
			valid_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s0 <= side_in;
		end
	end

	// u chain: atan2(|x|, |z|)
	logic             u_vld  [CORDIC_STEPS+1];
	vtg_pkg::cordic_t u_st   [CORDIC_STEPS+1];
	vtg_pkg::side_t   u_side [CORDIC_STEPS+1];

	assign u_vld[0]  = valid_s0;
	assign u_st[0].x = vtg_pkg::XW'(side_s0.az);
	assign u_st[0].y = vtg_pkg::XW'(side_s0.ax);
	assign u_st[0].z = '0;
	assign u_side[0] = side_s0;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_ucell
		vtg_cordic_cell #(.IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (u_vld[i]),
			.in_st    (u_st[i]),
			.in_side  (u_side[i]),
			.out_valid(u_vld[i+1]),
			.out_st   (u_st[i+1]),
			.out_side (u_side[i+1])
		);
	end

	// Round u angle; square the radial components
	logic signed [vtg_pkg::ZW-1:0] au_c;
	logic [vtg_pkg::ZW:0]          au_r;
	vtg_pkg::side_t                side_u;

	always_comb begin
		au_c   = u_st[CORDIC_STEPS].z[vtg_pkg::ZW-1] ? '0 : u_st[CORDIC_STEPS].z;
		au_r   = (vtg_pkg::ZW + 1)'(au_c) + HALF;
		side_u = u_side[CORDIC_STEPS];
		if (side_u.sph) begin
			side_u.cu = vtg_pkg::CW'(au_r >> SH);
		end
	end

	logic           valid_s1, valid_s2;
	vtg_pkg::side_t side_s1, side_s2;
	logic [63:0]    sqx_s1, sqz_s1, sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= u_vld[CORDIC_STEPS];
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_u;
			sqx_s1  <= 64'(side_u.ax) * 64'(side_u.ax);
			sqz_s1  <= 64'(side_u.az) * 64'(side_u.az);
			side_s2 <= side_s1;
			sq_s2   <= sqx_s1 + sqz_s1;
		end
	end

	// Square root chain: h = floor(sqrt(x^2 + z^2))
	logic            q_vld  [vtg_pkg::SQ_STEPS+1];
	vtg_pkg::isqrt_t q_st   [vtg_pkg::SQ_STEPS+1];
	vtg_pkg::side_t  q_side [vtg_pkg::SQ_STEPS+1];

	assign q_vld[0]    = valid_s2;
	assign q_st[0].n   = sq_s2;
	assign q_st[0].res = '0;
	assign q_side[0]   = side_s2;

	for (genvar k = 0; k < vtg_pkg::SQ_STEPS; k++) begin : g_qcell
		vtg_isqrt_cell #(.K(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (q_vld[k]),
			.in_st    (q_st[k]),
			.in_side  (q_side[k]),
			.out_valid(q_vld[k+1]),
			.out_st   (q_st[k+1]),
			.out_side (q_side[k+1])
		);
	end

	// v chain: atan2(h, |y|)
	logic             v_vld  [CORDIC_STEPS+1];
	vtg_pkg::cordic_t v_st   [CORDIC_STEPS+1];
	vtg_pkg::side_t   v_side [CORDIC_STEPS+1];

	assign v_vld[0]  = q_vld[vtg_pkg::SQ_STEPS];
	assign v_st[0].x = vtg_pkg::XW'(q_side[vtg_pkg::SQ_STEPS].ay);
	assign v_st[0].y = vtg_pkg::XW'(q_st[vtg_pkg::SQ_STEPS].res[31:0]);
	assign v_st[0].z = '0;
	assign v_side[0] = q_side[vtg_pkg::SQ_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vcell
		vtg_cordic_cell #(.IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (v_vld[i]),
			.in_st    (v_st[i]),
			.in_side  (v_side[i]),
			.out_valid(v_vld[i+1]),
			.out_st   (v_st[i+1]),
			.out_side (v_side[i+1])
		);
	end

	// Fold to acos range for negative y and round v
	logic signed [vtg_pkg::ZW-1:0] av_c, av_f;
	logic [vtg_pkg::ZW:0]          av_r;
	vtg_pkg::side_t                side_v;

	always_comb begin
		av_c = v_st[CORDIC_STEPS].z[vtg_pkg::ZW-1] ? '0 : v_st[CORDIC_STEPS].z;
		av_f = v_side[CORDIC_STEPS].yneg ? vtg_pkg::ZW'(vtg_pkg::PI_Q30) - av_c : av_c;
		av_r = (vtg_pkg::ZW + 1)'(av_f) + HALF;
		side_v = v_side[CORDIC_STEPS];
		if (side_v.sph) begin
			side_v.cv = vtg_pkg::CW'(av_r >> SH);
		end
	end

	logic                          valid_s3;
	logic signed [vtg_pkg::CW-1:0] cu_s3, cv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= v_vld[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cu_s3 <= side_v.cu;
			cv_s3 <= side_v.cv;
		end
	end

	// Scale, offset, saturate; its last register is the output register
	vtg_affine #(.FRAC_BITS(FRAC_BITS)) u_affine (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s3),
		.cu       (cu_s3),
		.cv       (cv_s3),
		.factor_u (factor_u_q),
		.factor_v (factor_v_q),
		.offset_u (offset_u_q),
		.offset_v (offset_v_q),
		.out_valid(out_valid),
		.out_data (out_data)
	);

endmodule

// ----- rtl/vtg_checker.sv -----
// ----------------------------------------------------------------------------
// vtg_checker
// Port-level checks on the texture coordinate generator, bound to the core.
// ----------------------------------------------------------------------------
module vtg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input vtg_pkg::out_item_t out_data
);

	// A stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Input is never refused while the output side is free
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("in_ready low with free output");

	// Back-pressure only comes from a waiting result
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low without a stalled result");

	// No result straight out of reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present after reset");

endmodule

bind vertex_texcoord_generator_core vtg_checker u_vtg_checker (.*);
